>>> rtl/hwp_pkg.sv
package hwp_pkg;

  // Default pyramid depth; a frame holds 2^LEVELS samples
  localparam int LEVELS_DEF = 10;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int LEVEL_W  = 4;
  localparam int POS_W    = 10;
  localparam int KEPT_W   = 4;

  // Stream packing
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_KEPT_LEVELS = '0;
  localparam logic [KEPT_W-1:0] KEPT_RESET      = 4'd4;

  // Fixed point: 1/sqrt2 in Q15
  localparam int SUM_W  = COEF_W + 1;
  localparam int K_W    = 16;
  localparam int PROD_W = SUM_W + K_W;
  localparam int FRAC_W = 15;
  localparam int QUOT_W = PROD_W - FRAC_W;
  localparam logic signed [K_W-1:0]    INV_SQRT2_Q15 = 16'sd23170;
  localparam logic signed [PROD_W-1:0] ROUND_HALF    = PROD_W'(1 << (FRAC_W - 1));

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_MULA,
    ST_MULD,
    ST_PUTA,
    ST_PUTD
  } hwp_state_t;

  // One result held in the output register
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [LEVEL_W-1:0]       level;
    logic [POS_W-1:0]         pos;
    logic                     is_detail;
    logic                     last;
  } hwp_result_t;

  // Round to nearest (ties up) after the Q15 product, then clamp to 24 bits
  function automatic logic signed [COEF_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [QUOT_W-1:0] q;
    logic [QUOT_W-COEF_W:0]   hi;
    logic signed [COEF_W-1:0] r;
    t  = p + ROUND_HALF;
    q  = t[PROD_W-1:FRAC_W];
    hi = q[QUOT_W-1:COEF_W-1];
    if ((&hi) || !(|hi)) begin
      r = q[COEF_W-1:0];
    end else if (q[QUOT_W-1]) begin
      r = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/haar_wavelet_pyramid.sv
// Channel | Dir | Ports        | Contents
// in      | in  | in_t*        | tdata[15:0] sample
// out     | out | out_t*       | tdata[23:0] coefficient, [27:24] level, [37:28] position;
//         |     |              | tuser is_detail; tlast last
// cfg     | in  | cfg_p*       | 0x0 kept_levels[3:0]
//
// The back end holds a sample at an even frame position at its level. Each level that
// combines a pair steps through LEVEL, MULA, MULD, PUTA and, if it emits, PUTD; the
// shared Q15 multiplier, used once for each of approximation and detail, sets this order.
// Reset (synchronous, rst_n low) clears the frame position, the queue and the output.
// A two-entry queue lets input continue while the back end waits on out_tready.
module haar_wavelet_pyramid import hwp_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // [15:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,    // [23:0] coefficient, [27:24] level,
                                               // [37:28] position, [39:38] zero
  output logic                   out_tuser,    // [0] is_detail
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [KEPT_W-1:0]   kept_r, kept_nxt;
  logic                q_valid;
  logic                q_pop;
  logic [SAMPLE_W-1:0] q_sample;
  logic [LEVELS-1:0]   q_pos;
  hwp_result_t         res;
  logic                cfg_wr;
  logic                reg_hit;

  // Register port
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_KEPT_LEVELS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_hit ? CFG_DW'(kept_r) : '0;

  always_comb begin
    kept_nxt = (cfg_wr && reg_hit) ? cfg_pwdata[KEPT_W-1:0] : kept_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= KEPT_RESET;
    end else begin
      kept_r <= kept_nxt;
    end
  end

  hwp_front #(.LEVELS(LEVELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_sample  (q_sample),
    .q_pos     (q_pos)
  );

  hwp_back #(.LEVELS(LEVELS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .kept_levels (kept_r),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_sample    (q_sample),
    .q_pos       (q_pos),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  // Pack the result
  assign out_tdata = OUT_TDATA_W'({res.pos, res.level, res.coef});
  assign out_tuser = res.is_detail;
  assign out_tlast = res.last;

endmodule

>>> rtl/hwp_front.sv
module hwp_front import hwp_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                q_valid,
  input  logic                q_pop,
  output logic [SAMPLE_W-1:0] q_sample,
  output logic [LEVELS-1:0]   q_pos
);

  logic [LEVELS-1:0]   count_r, count_nxt;
  logic [SAMPLE_W-1:0] qs_r [2];
  logic [LEVELS-1:0]   qp_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          fill_r, fill_nxt;
  logic                push;

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_sample  = qs_r[rd_ptr_r];
  assign q_pos     = qp_r[rd_ptr_r];

  // Tag each request with its frame position, advance pointers
  always_comb begin
    count_nxt  = push ? count_r + 1'b1 : count_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      qs_r[wr_ptr_r] <= in_sample;
      qp_r[wr_ptr_r] <= count_r;
    end
  end

endmodule

>>> rtl/hwp_back.sv
module hwp_back import hwp_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [KEPT_W-1:0]   kept_levels,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [SAMPLE_W-1:0] q_sample,
  input  logic [LEVELS-1:0]   q_pos,
  output logic                out_valid,
  input  logic                out_ready,
  output hwp_result_t         out_res
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LEVEL_W-1:0] LEV_TOP = LEVEL_W'(LEVELS - 1);

  hwp_state_t                state_r, state_nxt;
  logic signed [COEF_W-1:0]  v_r, v_nxt;
  logic [LEVELS-1:0]         n_r, n_nxt;
  logic [LEVEL_W-1:0]        lev_r, lev_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [SUM_W-1:0]   diff_r, diff_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [COEF_W-1:0]  a_r, a_nxt;
  hwp_result_t               res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COEF_W-1:0]  pend_r [LEVELS];

  logic signed [COEF_W-1:0]  pend_rd;
  logic                      pend_we;
  logic signed [SUM_W-1:0]   mul_op;
  logic signed [PROD_W-1:0]  mul_out;
  logic [LEVELS-1:0]         n_up;
  logic                      emit;
  logic                      slot_free;
  logic                      last_d;

  assign pend_rd   = pend_r[lev_r[LW-1:0]];
  assign mul_op    = (state_r == ST_MULA) ? sum_r : diff_r;
  assign mul_out   = mul_op * INV_SQRT2_Q15;
  assign n_up      = n_r >> 1;
  assign emit      = (lev_r < LEVEL_W'(kept_levels));
  assign slot_free = !out_valid_r || out_ready;
  assign last_d    = (lev_r == '0) || !n_up[0];

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Walk one level per pass: hold an even value, or combine with the held one
  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    n_nxt         = n_r;
    lev_nxt       = lev_r;
    sum_nxt       = sum_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    a_nxt         = a_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    pend_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          v_nxt     = {{(COEF_W-SAMPLE_W){q_sample[SAMPLE_W-1]}}, q_sample};
          n_nxt     = q_pos;
          lev_nxt   = LEV_TOP;
          state_nxt = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (!n_r[0]) begin
          pend_we   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          sum_nxt   = SUM_W'(pend_rd) + SUM_W'(v_r);
          diff_nxt  = SUM_W'(pend_rd) - SUM_W'(v_r);
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        prod_nxt  = mul_out;
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        a_nxt     = round_sat(prod_r);
        prod_nxt  = mul_out;
        state_nxt = ST_PUTA;
      end
      ST_PUTA: begin
        if (emit) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '{coef: a_r, level: lev_r, pos: POS_W'(n_up),
                              is_detail: 1'b0, last: 1'b0};
            state_nxt     = ST_PUTD;
          end
        end else begin
          // Pass the approximation down without emitting
          v_nxt = a_r;
          if (lev_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_up;
            lev_nxt   = lev_r - 1'b1;
            state_nxt = ST_LEVEL;
          end
        end
      end
      ST_PUTD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{coef: round_sat(prod_r), level: lev_r, pos: POS_W'(n_up),
                            is_detail: 1'b1, last: last_d};
          v_nxt         = a_r;
          if (lev_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_up;
            lev_nxt   = lev_r - 1'b1;
            state_nxt = ST_LEVEL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    n_r    <= n_nxt;
    lev_r  <= lev_nxt;
    sum_r  <= sum_nxt;
    diff_r <= diff_nxt;
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    res_r  <= res_nxt;
  end

  // Held even value per level
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_r[lev_r[LW-1:0]] <= v_r;
    end
  end

endmodule

>>> rtl/hwp_checker.sv
module hwp_checker import hwp_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset drops the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An approximation never carries last, since its detail always follows it
  a_approx_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tlast)
    else $error("approximation marked last");

  // Level stays within the pyramid
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[COEF_W+LEVEL_W-1:COEF_W] <= LEVEL_W'(LEVELS - 1))
    else $error("level out of range");

endmodule

bind haar_wavelet_pyramid hwp_checker #(.LEVELS(LEVELS)) u_hwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/haar_coef_checker.sv
`timescale 1ns / 100ps

// Watch the sample, result and register channels, predict each coefficient the
// pyramid must release and compare every accepted result with the oldest one owed.
module haar_coef_checker import hwp_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // [15:0] sample
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,    // [23:0] coefficient, [27:24] level,
                                               // [37:28] position, [39:38] zero
  input  logic                   out_tuser,    // [0] is_detail
  input  logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     fail_count,
  output int                     coefs_owed
);

  localparam longint COEF_HI = (longint'(1) <<< (COEF_W - 1)) - 1;
  localparam longint COEF_LO = -(longint'(1) <<< (COEF_W - 1));
  localparam int     REPORT_MAX = 10;

  logic [KEPT_W-1:0]        kept = KEPT_RESET;
  logic [LEVELS-1:0]        frame_pos = '0;
  logic signed [COEF_W-1:0] held_even [LEVELS];
  hwp_result_t              owed_coefs [$];
  int                       errors = 0;

  // Scale by 1/sqrt2 in Q15, round half toward plus infinity, clamp to 24 bits
  function automatic logic signed [COEF_W-1:0] scale_q15(input longint x);
    longint p;
    p = (x * longint'(INV_SQRT2_Q15) + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (p > COEF_HI) p = COEF_HI;
    if (p < COEF_LO) p = COEF_LO;
    return p[COEF_W-1:0];
  endfunction

  // Push one sample down the pyramid and queue the coefficients it releases
  function automatic void predict_coefs(input logic signed [SAMPLE_W-1:0] smp);
    hwp_result_t              batch [2*LEVELS];
    hwp_result_t              r;
    int                       n_out;
    int                       lev;
    longint                   v;
    logic signed [COEF_W-1:0] approx;
    logic signed [COEF_W-1:0] detail;
    bit                       settled;
    n_out   = 0;
    v       = smp;
    settled = 1'b0;
    for (int m = 0; m < LEVELS; m++) begin
      if (!settled) begin
        lev = LEVELS - 1 - m;
        if (!frame_pos[m]) begin
          // even position at this level: hold the value and stop
          held_even[lev] = v[COEF_W-1:0];
          settled = 1'b1;
        end else begin
          approx = scale_q15(longint'(held_even[lev]) + v);
          detail = scale_q15(longint'(held_even[lev]) - v);
          if (lev < int'(kept)) begin
            r.coef      = approx;
            r.level     = lev[LEVEL_W-1:0];
            r.pos       = POS_W'(frame_pos >> (m + 1));
            r.is_detail = 1'b0;
            r.last      = 1'b0;
            batch[n_out] = r;
            r.coef      = detail;
            r.is_detail = 1'b1;
            batch[n_out+1] = r;
            n_out = n_out + 2;
          end
          // approximation feeds the next coarser level
          v = approx;
        end
      end
    end
    for (int i = 0; i < n_out; i++) begin
      r = batch[i];
      r.last = (i == n_out - 1);
      owed_coefs.push_back(r);
    end
    frame_pos = frame_pos + 1'b1;
  endfunction

  always @(posedge clk) begin : track
    hwp_result_t got;
    hwp_result_t want;
    if (!rst_n) begin
      kept      = KEPT_RESET;
      frame_pos = '0;
      owed_coefs.delete();
    end else begin
      // Compare an accepted result with the oldest owed coefficient
      if (out_tvalid && out_tready) begin
        got.coef      = out_tdata[COEF_W-1:0];
        got.level     = out_tdata[COEF_W +: LEVEL_W];
        got.pos       = out_tdata[COEF_W+LEVEL_W +: POS_W];
        got.is_detail = out_tuser;
        got.last      = out_tlast;
        if (owed_coefs.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("%0t: unexpected result coef=%0d level=%0d pos=%0d detail=%0b last=%0b",
                     $time, $signed(got.coef), got.level, got.pos, got.is_detail, got.last);
          end
        end else begin
          want = owed_coefs.pop_front();
          if (got.coef !== want.coef || got.level !== want.level || got.pos !== want.pos ||
              got.is_detail !== want.is_detail || got.last !== want.last) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("%0t: mismatch expected coef=%0d level=%0d pos=%0d detail=%0b last=%0b",
                       $time, $signed(want.coef), want.level, want.pos, want.is_detail,
                       want.last);
              $display("%0t:          actual coef=%0d level=%0d pos=%0d detail=%0b last=%0b",
                       $time, $signed(got.coef), got.level, got.pos, got.is_detail, got.last);
            end
          end
        end
      end
      // Predict from an accepted sample request
      if (in_tvalid && in_tready) begin
        predict_coefs(in_tdata[SAMPLE_W-1:0]);
      end
      // Follow register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_KEPT_LEVELS) begin
        kept = cfg_pwdata[KEPT_W-1:0];
      end
    end
    fail_count <= errors;
    coefs_owed <= owed_coefs.size();
  end

endmodule

>>> tb/haar_wavelet_pyramid_test.sv
`timescale 1ns / 100ps

module haar_wavelet_pyramid_test;
  import hwp_pkg::*;

  localparam int SETTLE_CYCLES = 200;   // room for a few samples still in flight
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int CORNER_COUNT  = 24;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;    // [15:0] sample
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;           // [23:0] coefficient, [27:24] level,
                                               // [37:28] position, [39:38] zero
  logic                   out_tuser;           // [0] is_detail
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int         fail_count;
  int         coefs_owed;
  idle_mode_t idle_mode  = IDLE_NONE;
  int         hold_req   = 0;
  int         hold_taken = 0;
  int         hold_left  = 0;
  int         quiet      = 0;

  // Extremes, sign flips and alternating bit patterns, taken in pairs
  logic [SAMPLE_W-1:0] corner_samples [CORNER_COUNT] = '{
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
    16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001,
    16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
    16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000
  };

  haar_wavelet_pyramid dut (.*);

  haar_coef_checker coef_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drive out_tready: long hold on request, else random stalls by phase
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_taken) begin
      hold_taken <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_tready <= ($urandom_range(99) >= 76);
        IDLE_BOTH: out_tready <= ($urandom_range(99) >= 10);
        default:   out_tready <= 1'b1;
      endcase
    end
  end

  // Abort when no request moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 76;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  // Mostly full-range values, with extremes and small values mixed in
  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] r;
    r = SAMPLE_W'($urandom);
    case ($urandom_range(7))
      0:       r = 16'h7FFF;
      1:       r = 16'h8000;
      2:       r = {{(SAMPLE_W-4){r[3]}}, r[3:0]};
      default: ;
    endcase
    return r;
  endfunction

  // Offer one sample request and hold it until accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    while (sender_rests()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(input int count, input idle_mode_t mode);
    idle_mode <= mode;
    for (int i = 0; i < count; i++) begin
      send_sample(random_sample());
    end
  endtask

  // Drop valid and wait until every owed coefficient has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (coefs_owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Let the back end finish samples that release nothing, then reprogram
  task automatic change_kept(input logic [KEPT_W-1:0] kept);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg({REG_KEPT_LEVELS, 2'b00}, CFG_DW'(kept));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: only levels 0 to 3 emit
    send_random(40, IDLE_NONE);

    // All levels emit; corner pairs start on an even frame position
    change_kept(4'd10);
    idle_mode <= IDLE_NONE;
    for (int i = 0; i < CORNER_COUNT; i++) begin
      send_sample(corner_samples[i]);
    end

    // Nothing emits, the frame position still advances
    change_kept(4'd0);
    send_random(30, IDLE_SEND);
    change_kept(4'd7);
    send_random(60, IDLE_RECV);

    // Above the level count every level emits; kept 5 then limits it to levels 0 to 4
    change_kept(4'd15);
    send_random(90, IDLE_BOTH);
    change_kept(4'd11);
    send_random(40, IDLE_SEND);
    change_kept(4'd5);
    send_random(50, IDLE_RECV);

    // Long output hold while samples keep coming, then a full drain mid-stream
    change_kept(4'd10);
    hold_req <= hold_req + 1;
    send_random(40, IDLE_NONE);
    drain();
    send_random(40, IDLE_NONE);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
